>>> design/lpr_pkg.sv
// Package for the LRU page replacement block: sizes, page width helpers,
// controller state type and the command and status structs.
// No dependencies; used by lpr_ctrl, lpr_datapath and lru_page_replacement.
`default_nettype none
package lpr_pkg;

   localparam int NUM_FRAMES = 16;
   localparam int PAGE_BITS  = 32;

   localparam int IDX_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int COUNT_W = $clog2(NUM_FRAMES + 1);
   localparam int PORT_W  = 32;
   localparam int CSR_W   = 5;
   localparam logic [CSR_W-1:0] SLOTS_RESET = CSR_W'(4);

   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [COUNT_W-1:0]   count_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } lpr_state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } lpr_cmd_type;

   typedef struct packed {
      logic out_free;
   } lpr_status_type;

   function automatic page_type to_page(input logic [PORT_W-1:0] p);
      logic [63:0] w;
      w = {32'd0, p};
      return w[PAGE_BITS-1:0];
   endfunction

   function automatic logic [PORT_W-1:0] from_page(input page_type pg);
      logic [63:0] w;
      w = 64'(pg);
      return w[PORT_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> design/lpr_ctrl.sv
// Controller state machine for the LRU page replacement block.
// Depends on lpr_pkg; drives commands to lpr_datapath.
`default_nettype none
module lpr_ctrl
   import lpr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire lpr_status_type status,
   output lpr_cmd_type         cmd
);

   lpr_state_type state_ff;
   lpr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> design/lpr_datapath.sv
// Datapath for the LRU page replacement block: frame table, recency ranks,
// tag compare, victim selection, fault counter and the result word register.
// Depends on lpr_pkg; commanded by lpr_ctrl.
`default_nettype none
module lpr_datapath
   import lpr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lpr_cmd_type       cmd,
   output lpr_status_type         status,
   input  wire logic [PORT_W-1:0] req_page_number,
   input  wire logic              req_first_reference,
   input  wire logic              req_last_reference,
   input  wire logic              csr_write_enable,
   input  wire logic [CSR_W-1:0]  csr_write_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_page_fault,
   output logic                   rsp_evicted_valid,
   output logic [PORT_W-1:0]      rsp_evicted_page,
   output logic [PORT_W-1:0]      rsp_fault_count,
   output logic                   rsp_sequence_done
);

   logic [CSR_W-1:0]      slots_ff;
   page_type              frame_page_ff [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] frame_valid_ff;
   idx_type               frame_rank_ff [NUM_FRAMES];
   count_type             count_ff;
   logic [PORT_W-1:0]     fault_total_ff;

   page_type              page_ff;
   logic                  last_ff;

   logic                  hit_ff;
   logic                  fill_ff;
   idx_type               slot_ff;
   idx_type               hit_rank_ff;

   logic                  out_full_ff;
   logic                  out_fault_ff;
   logic                  out_ev_valid_ff;
   logic [PORT_W-1:0]     out_ev_page_ff;
   logic [PORT_W-1:0]     out_count_ff;
   logic                  out_done_ff;

   count_type             cap;
   logic                  hit_any;
   idx_type               hit_idx;
   idx_type               free_idx;
   idx_type               victim_idx;
   idx_type               oldest_rank;
   count_type             count_less;
   logic [PORT_W-1:0]     fault_total_in;
   logic                  fill_now;

   always_comb begin
      if (slots_ff == '0) begin
         cap = COUNT_W'(1);
      end else if (32'(slots_ff) > NUM_FRAMES) begin
         cap = COUNT_W'(NUM_FRAMES);
      end else begin
         cap = COUNT_W'(slots_ff);
      end
   end

   always_comb begin
      hit_any    = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      victim_idx = '0;
      count_less = count_ff - COUNT_W'(1);
      oldest_rank = count_less[IDX_W-1:0];
      for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
         if (frame_valid_ff[i] && frame_page_ff[i] == page_ff) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!frame_valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
         if (frame_valid_ff[i] && frame_rank_ff[i] == oldest_rank) begin
            victim_idx = IDX_W'(i);
         end
      end
      fill_now = (count_ff < cap);
   end

   always_comb begin
      if (fault_total_ff == '1) begin
         fault_total_in = fault_total_ff;
      end else begin
         fault_total_in = fault_total_ff + PORT_W'(1);
      end
   end

   assign status.out_free = !out_full_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
      end else if (csr_write_enable) begin
         slots_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff <= to_page(req_page_number);
         last_ff <= req_last_reference;
      end
      if (cmd.lookup) begin
         hit_ff      <= hit_any;
         fill_ff     <= fill_now;
         hit_rank_ff <= frame_rank_ff[hit_idx];
         if (hit_any) begin
            slot_ff <= hit_idx;
         end else if (fill_now) begin
            slot_ff <= free_idx;
         end else begin
            slot_ff <= victim_idx;
         end
      end
      if (cmd.commit && !hit_ff) begin
         frame_page_ff[slot_ff] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         count_ff       <= '0;
         fault_total_ff <= '0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            frame_rank_ff[i] <= '0;
         end
      end else if (cmd.capture && req_first_reference) begin
         frame_valid_ff <= '0;
         count_ff       <= '0;
         fault_total_ff <= '0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            frame_rank_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            if (IDX_W'(i) == slot_ff) begin
               frame_rank_ff[i]  <= '0;
               frame_valid_ff[i] <= 1'b1;
            end else if (frame_valid_ff[i] &&
                         (!hit_ff || frame_rank_ff[i] < hit_rank_ff)) begin
               frame_rank_ff[i] <= frame_rank_ff[i] + IDX_W'(1);
            end
         end
         if (!hit_ff) begin
            fault_total_ff <= fault_total_in;
            if (fill_ff) begin
               count_ff <= count_ff + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_full_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_fault_ff    <= !hit_ff;
         out_ev_valid_ff <= !hit_ff && !fill_ff;
         out_ev_page_ff  <= (!hit_ff && !fill_ff) ? from_page(frame_page_ff[slot_ff]) : '0;
         out_count_ff    <= hit_ff ? fault_total_ff : fault_total_in;
         out_done_ff     <= last_ff;
      end
   end

   assign rsp_valid         = out_full_ff;
   assign rsp_page_fault    = out_fault_ff;
   assign rsp_evicted_valid = out_ev_valid_ff;
   assign rsp_evicted_page  = out_ev_page_ff;
   assign rsp_fault_count   = out_count_ff;
   assign rsp_sequence_done = out_done_ff;

   // The resident count always matches the number of valid frames.
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      32'($countones(frame_valid_ff)) == 32'(count_ff))
      else $error("resident count differs from valid frames");

   a_evict_implies_fault: assert property (@(posedge clock) disable iff (reset)
      out_full_ff && out_ev_valid_ff |-> out_fault_ff)
      else $error("eviction reported without a fault");

   a_commit_loads_output: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> out_full_ff)
      else $error("result word not loaded after commit");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!out_full_ff || !rsp_stall))
      else $error("result word overwritten while stalled");

endmodule
`default_nettype wire

>>> design/lru_page_replacement.sv
// LRU page replacement, top level: one page reference in, one result word out.
// Each reference is accepted, tag compared and then committed into the
// registered result word; commit waits while the result word is stalled, and
// no new reference is taken until it commits. The frame table is a single set.
// Synchronous active-high reset empties the set, zeroes the fault count and
// sets the capacity register to four frames.
`default_nettype none
module lru_page_replacement
   import lpr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [PORT_W-1:0] req_page_number,
   input  wire logic              req_first_reference,
   input  wire logic              req_last_reference,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_page_fault,
   output logic                   rsp_evicted_valid,
   output logic [PORT_W-1:0]      rsp_evicted_page,
   output logic [PORT_W-1:0]      rsp_fault_count,
   output logic                   rsp_sequence_done,
   input  wire logic              csr_write_enable,
   input  wire logic [CSR_W-1:0]  csr_write_data
);

   lpr_cmd_type    cmd;
   lpr_status_type status;

   lpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lpr_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_page_number     (req_page_number),
      .req_first_reference (req_first_reference),
      .req_last_reference  (req_last_reference),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_page_fault      (rsp_page_fault),
      .rsp_evicted_valid   (rsp_evicted_valid),
      .rsp_evicted_page    (rsp_evicted_page),
      .rsp_fault_count     (rsp_fault_count),
      .rsp_sequence_done   (rsp_sequence_done)
   );

endmodule
`default_nettype wire
